[rtl/ogi_pkg.sv]
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared types and constants of the obstacle inflation core.
// ----------------------------------------------------------------------------
package ogi_pkg;

	localparam int RADIUS_W  = 4;
	localparam int GRID_W    = 9;
	localparam int COORD_W   = 8;
	localparam int CLASS_W   = 2;
	localparam int GRAY_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [CLASS_W-1:0] CLS_FREE     = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_OCCUPIED = 2'd1;

	localparam logic [GRAY_W-1:0] GRAY_FREE     = 8'd255;
	localparam logic [GRAY_W-1:0] GRAY_OCCUPIED = 8'd0;
	localparam logic [GRAY_W-1:0] GRAY_UNKNOWN  = 8'd128;
	localparam logic [GRAY_W-1:0] GRAY_QUERY    = 8'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MARK
	} state_t;

endpackage

[rtl/ogi_window.sv]
// ----------------------------------------------------------------------------
// ogi_window
// Clipped inflation window of one cell: row bounds, column mask and the
// inside-grid flag.
// ----------------------------------------------------------------------------
module ogi_window #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256,
	parameter int XW       = 10
) (
	input  logic [ogi_pkg::RADIUS_W-1:0] radius,
	input  logic [ogi_pkg::GRID_W-1:0]   grid_rows,
	input  logic [ogi_pkg::GRID_W-1:0]   grid_cols,
	input  logic [ogi_pkg::COORD_W-1:0]  row,
	input  logic [ogi_pkg::COORD_W-1:0]  col,
	output logic [XW-1:0]                row_lo,
	output logic [XW-1:0]                row_hi,
	output logic                         rows_ok,
	output logic                         in_grid,
	output logic [MAX_COLS-1:0]          col_mask
);
	import ogi_pkg::*;

	logic [XW-1:0] nr;
	logic [XW-1:0] nc;
	logic [XW-1:0] rx;
	logic [XW-1:0] cx;
	logic [XW-1:0] rd;
	logic [XW-1:0] row_end;
	logic [XW-1:0] col_lo;
	logic [XW-1:0] col_end;
	logic [XW-1:0] col_hi;

	always_comb begin
		nr = (XW'(grid_rows) > XW'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(grid_rows);
		nc = (XW'(grid_cols) > XW'(MAX_COLS)) ? XW'(MAX_COLS) : XW'(grid_cols);
		rx = XW'(row);
		cx = XW'(col);
		rd = XW'(radius);

		row_lo  = (rx > rd) ? rx - rd : '0;
		row_end = rx + rd;
		row_hi  = (row_end >= nr) ? nr - XW'(1) : row_end;

		col_lo  = (cx > rd) ? cx - rd : '0;
		col_end = cx + rd;
		col_hi  = (col_end >= nc) ? nc - XW'(1) : col_end;

		rows_ok = (nr != '0) && (nc != '0) && (row_lo <= row_hi);
		in_grid = (rx < nr) && (cx < nc);

		for (int j = 0; j < MAX_COLS; j++) begin
			col_mask[j] = (nc != '0) && (XW'(j) >= col_lo) && (XW'(j) <= col_hi);
		end
	end

endmodule

[rtl/occupancy_grid_obstacle_inflation_core.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_inflation_core
// One-bit inflated obstacle map held as rows of a synchronous memory.
// Occupied loads OR a clipped square window into the map row by row.
// ----------------------------------------------------------------------------
//  channel   signals                                  handshake
//  input     func, row, col, cell_class               start & !busy
//  result    gray_level, is_blocked                   done, one cycle
//  config    cfg_index, cfg_wdata                     cfg_we
//
//  Query, free or unknown load: one row read of the map memory.
//  Occupied load: the read-modify-write of the window rows is pipelined
//  through the memory, one row read per cycle.
//  After reset a clearing pass writes MAX_ROWS rows, one a cycle; busy is
//  high meanwhile. Config writes are taken at any time.
//  The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_inflation_core #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [ogi_pkg::COORD_W-1:0]   row,
	input  logic [ogi_pkg::COORD_W-1:0]   col,
	input  logic [ogi_pkg::CLASS_W-1:0]   cell_class,
	input  logic                          cfg_we,
	input  logic [ogi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ogi_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output logic                          done,
	output logic [ogi_pkg::GRAY_W-1:0]    gray_level,
	output logic                          is_blocked
);
	import ogi_pkg::*;

	localparam int AW  = $clog2(MAX_ROWS);
	localparam int CAW = $clog2(MAX_COLS);
	localparam int RW1 = $clog2(MAX_ROWS + 1);
	localparam int CW1 = $clog2(MAX_COLS + 1);
	localparam int XW  = (RW1 > CW1) ? ((RW1 > 10) ? RW1 : 10) : ((CW1 > 10) ? CW1 : 10);

	// config
	logic [RADIUS_W-1:0] radius_q;
	logic [GRID_W-1:0]   grid_rows_q;
	logic [GRID_W-1:0]   grid_cols_q;

	// control
	state_t        state_q;
	state_t        state_nxt;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] ptr_q;
	logic          rdv_s1;

	// item
	logic [XW-1:0]       r1_q;
	logic [XW-1:0]       col_x_q;
	logic                mark_en_q;
	logic                inside_q;
	logic [GRAY_W-1:0]   gray_q;
	logic [MAX_COLS-1:0] mask_q;

	// window
	logic [XW-1:0]       win_lo;
	logic [XW-1:0]       win_hi;
	logic                win_ok;
	logic                win_inside;
	logic [MAX_COLS-1:0] win_mask;

	// memory
	logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
	logic [MAX_COLS-1:0] rdata_s1;
	logic [AW-1:0]       row_s1;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	// result
	logic                accept;
	logic                res_valid;
	logic                res_blocked;
	logic [GRAY_W-1:0]   gray_in;
	logic                done_q;
	logic [GRAY_W-1:0]   gray_level_q;
	logic                is_blocked_q;

	ogi_window #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.XW       (XW)
	) u_window (
		.radius    (radius_q),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.row       (row),
		.col       (col),
		.row_lo    (win_lo),
		.row_hi    (win_hi),
		.rows_ok   (win_ok),
		.in_grid   (win_inside),
		.col_mask  (win_mask)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		if (func == FUNC_QUERY) begin
			gray_in = GRAY_QUERY;
		end else begin
			unique case (cell_class)
				CLS_FREE:     gray_in = GRAY_FREE;
				CLS_OCCUPIED: gray_in = GRAY_OCCUPIED;
				default:      gray_in = GRAY_UNKNOWN;
			endcase
		end
	end

	always_comb begin
		state_nxt   = state_q;
		rd_en       = 1'b0;
		rd_addr     = row[AW-1:0];
		res_valid   = 1'b0;
		res_blocked = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MAX_ROWS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = XW'(row) >= XW'(MAX_ROWS) ? '0 : AW'(XW'(row));
				if (start) begin
					if (func == FUNC_LOAD && cell_class == CLS_OCCUPIED) begin
						state_nxt = ST_MARK;
					end else begin
						rd_en     = 1'b1;
						state_nxt = ST_READ;
					end
				end
			end
			ST_READ: begin
				res_valid   = 1'b1;
				res_blocked = inside_q && rdata_s1[col_x_q[CAW-1:0]];
				state_nxt   = ST_IDLE;
			end
			ST_MARK: begin
				rd_addr = ptr_q[AW-1:0];
				if (mark_en_q && ptr_q <= r1_q) begin
					rd_en = 1'b1;
				end else begin
					res_valid   = 1'b1;
					res_blocked = inside_q;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = rdv_s1;
			wr_addr = row_s1;
			wr_data = rdata_s1 | mask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			rdv_s1      <= 1'b0;
			done_q      <= 1'b0;
			radius_q    <= '0;
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_valid;
			rdv_s1  <= rd_en && (state_q == ST_MARK);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				ptr_q <= win_lo;
			end else if (rd_en && state_q == ST_MARK) begin
				ptr_q <= ptr_q + XW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RADIUS: radius_q    <= cfg_wdata[RADIUS_W-1:0];
					CFG_ROWS:   grid_rows_q <= cfg_wdata[GRID_W-1:0];
					CFG_COLS:   grid_cols_q <= cfg_wdata[GRID_W-1:0];
					default:    radius_q    <= radius_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r1_q      <= win_hi;
			col_x_q   <= XW'(col);
			mark_en_q <= win_ok;
			inside_q  <= win_inside;
			gray_q    <= gray_in;
			mask_q    <= win_mask;
		end
		if (res_valid) begin
			gray_level_q <= gray_q;
			is_blocked_q <= res_blocked;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
			row_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign done       = done_q;
	assign gray_level = gray_level_q;
	assign is_blocked = is_blocked_q;

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_READ || $past(state_q) == ST_MARK))
		else $error("result strobe without a finishing item");

	a_write_only_when_marking: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR || state_q == ST_MARK))
		else $error("map write outside clear or mark");

	a_no_pending_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_IDLE) |-> !rdv_s1)
		else $error("row write still pending while reading the map");

	a_occupied_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q) == ST_MARK) |-> (gray_level == GRAY_OCCUPIED))
		else $error("occupied load returned wrong gray level");

	a_mark_read_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> ($past(ptr_q) <= $past(r1_q) && $past(mark_en_q)))
		else $error("row written outside the window");

endmodule
